// File: design/sltt_pkg.sv
// Shared types and codes for the sorted leaf table unit
`timescale 1ns / 1ps
package sltt_pkg;
    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_MARK   = 3'd2;
    localparam logic [2:0] OP_PURGE  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_NOTFND  = 3'd3;
    localparam logic [2:0] ST_MARKED  = 3'd4;
    localparam logic [2:0] ST_MFULL   = 3'd5;
    localparam logic [2:0] ST_BADPOS  = 3'd6;

    // per-cell command from the controller
    typedef struct packed {
        logic ins;   // load at the insert point, shift up above it
        logic del;   // shift down at and above the removed position
    } t_cell_cmd;
endpackage

// File: design/sltt_cell.sv
// One table slot: holds a key/value, compares against the search key, shifts with neighbours
`timescale 1ns / 1ps
module sltt_cell import sltt_pkg::*; #(
    parameter int KEY_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_valid_slot,
    input  logic [KEY_BITS-1:0] i_key,
    input  t_cell_cmd           i_cmd,
    input  logic                i_ins_here,
    input  logic                i_ins_above,
    input  logic                i_del_above,
    input  logic [KEY_BITS-1:0] i_new_key,
    input  logic [63:0]         i_new_val,
    input  logic [KEY_BITS-1:0] i_lo_key,
    input  logic [63:0]         i_lo_val,
    input  logic [KEY_BITS-1:0] i_hi_key,
    input  logic [63:0]         i_hi_val,
    output logic [KEY_BITS-1:0] o_key,
    output logic [63:0]         o_val,
    output logic                o_eq,
    output logic                o_lt
);
    logic [KEY_BITS-1:0] r_key;
    logic [63:0]         r_val;

    assign o_key = r_key;
    assign o_val = r_val;
    assign o_eq  = i_valid_slot && (r_key == i_key);
    assign o_lt  = i_valid_slot && (r_key < i_key);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && i_ins_here) begin
            r_key <= i_new_key;
            r_val <= i_new_val;
        end else if (i_cmd.ins && i_ins_above) begin
            r_key <= i_lo_key;
            r_val <= i_lo_val;
        end else if (i_cmd.del && i_del_above) begin
            r_key <= i_hi_key;
            r_val <= i_hi_val;
        end
    end
endmodule

// File: design/sorted_leaf_table_with_tombstones_unit.sv
// Top level: sorted key/value table built as a chain of cells, with a pending-delete mark queue
`timescale 1ns / 1ps
// An operation proceeds in order after its input transfer. First every
// cell compares its key against the search key in parallel and the compare vectors are
// registered. Then the match/position is reduced and the shift of the cell chain
// and the mark queue is committed. The result sits in an output register and the input stays
// stalled while it waits, so a new transfer is taken in the cycle after the result has been
// handed over. The unit works on one operation at a time, and an output stall holds off the next.
// max_entries at APB address 0; values above CAPACITY act as CAPACITY.
module sorted_leaf_table_with_tombstones_unit import sltt_pkg::*; #(
    parameter int CAPACITY   = 256,
    parameter int MARK_DEPTH = 4,
    parameter int KEY_BITS   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_search_key,
    input  logic [63:0] i_entry_value,
    input  logic [7:0]  i_read_position,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic        o_hit,
    output logic [7:0]  o_position,
    output logic [63:0] o_key_out,
    output logic [63:0] o_value_out,
    output logic        o_is_marked,
    output logic [8:0]  o_entry_count,
    output logic [2:0]  o_mark_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = $clog2(MARK_DEPTH + 1);
    localparam int QW = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;

    logic [8:0]  r_max;
    logic [CW-1:0] r_used;
    logic [MW-1:0] r_mp;
    logic [PW-1:0] r_marks [MARK_DEPTH];
    logic          r_busy;
    logic [2:0]          r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [63:0]         r_vin;
    logic [7:0]          r_rp;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {23'd0, r_max} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max <= 9'd256;
        else if (psel && penable && pwrite && paddr == 2'd0) r_max <= pwdata[8:0];
    end

    assign o_stall = r_busy || o_valid;
    wire acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op  <= i_opcode;
            r_key <= i_search_key[KEY_BITS-1:0];
            r_vin <= i_entry_value;
            r_rp  <= i_read_position;
        end
    end

    // chain of cells
    logic [KEY_BITS-1:0] c_key [CAPACITY];
    logic [63:0]         c_val [CAPACITY];
    logic [CAPACITY-1:0] c_eq, c_lt;
    t_cell_cmd cmd;
    logic [PW-1:0] ins_p, del_p;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            localparam int LO = (g == 0) ? 0 : g - 1;
            localparam int HI = (g == CAPACITY - 1) ? g : g + 1;
            sltt_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                .i_clk       (i_clk),
                .i_valid_slot(CW'(g) < r_used),
                .i_key       (r_key),
                .i_cmd       (cmd),
                .i_ins_here  (ins_p == PW'(g)),
                .i_ins_above (PW'(g) > ins_p),
                .i_del_above (PW'(g) >= del_p),
                .i_new_key   (r_key),
                .i_new_val   (r_vin),
                .i_lo_key    (c_key[LO]),
                .i_lo_val    (c_val[LO]),
                .i_hi_key    (c_key[HI]),
                .i_hi_val    (c_val[HI]),
                .o_key       (c_key[g]),
                .o_val       (c_val[g]),
                .o_eq        (c_eq[g]),
                .o_lt        (c_lt[g])
            );
        end
    endgenerate

    // registered compare vectors for the reduce/commit cycle
    logic [CAPACITY-1:0] r_eq, r_lt;
    always_ff @(posedge i_clk) begin
        r_eq <= c_eq;
        r_lt <= c_lt;
    end
    logic r_cmp;  // compare cycle done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cmp <= 1'b0;
        else r_cmp <= r_busy && !r_cmp;
    end

    // lt is a prefix of the sorted valid slots, so the lower bound is one past its last set bit
    logic          found;
    logic [PW-1:0] fpos;
    logic [CW-1:0] lb;
    always_comb begin
        found = 1'b0;
        fpos  = '0;
        lb    = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_eq[i]) begin
                found = 1'b1;
                fpos  = PW'(i);
            end
            if (r_lt[i]) lb = CW'(i + 1);
        end
    end

    function automatic logic marked(input logic [PW-1:0] p, input logic [MW-1:0] n,
                                    input logic [PW-1:0] m [MARK_DEPTH]);
        logic r;
        r = 1'b0;
        for (int i = 0; i < MARK_DEPTH; i++)
            if (MW'(i) < n && m[i] == p) r = 1'b1;
        return r;
    endfunction

    logic [CW-1:0] limit;
    assign limit = (32'(r_max) > CAPACITY) ? CW'(CAPACITY) : CW'(r_max);

    logic [2:0] st;
    logic hit, ism, rep;
    logic [PW-1:0] rpos;
    logic [KEY_BITS-1:0] okey_k;
    logic [63:0] oval;
    logic [CW-1:0] n_used;
    logic [MW-1:0] n_mp;
    logic [PW-1:0] n_marks [MARK_DEPTH];
    logic [PW-1:0] m0;

    always_comb begin
        st = ST_OK; hit = 1'b0; ism = 1'b0; rep = 1'b0; rpos = '0;
        okey_k = '0; oval = '0;
        cmd = '0; ins_p = lb[PW-1:0]; del_p = '0;
        n_used = r_used; n_mp = r_mp; n_marks = r_marks;
        m0 = r_marks[0];
        case (r_op)
            OP_LOOKUP: begin
                if (!found) st = ST_NOTFND;
                else begin rep = 1'b1; rpos = fpos; end
            end
            OP_INSERT: begin
                if (found) begin st = ST_DUP; rep = 1'b1; rpos = fpos; end
                else if (r_used >= limit) st = ST_FULL;
                else begin
                    cmd.ins = 1'b1;
                    n_used = r_used + 1'b1;
                    for (int i = 0; i < MARK_DEPTH; i++)
                        if (MW'(i) < r_mp && CW'(r_marks[i]) >= lb)
                            n_marks[i] = r_marks[i] + 1'b1;
                    rpos = lb[PW-1:0]; okey_k = r_key; oval = r_vin;
                end
            end
            OP_MARK: begin
                if (!found) st = ST_NOTFND;
                else if (marked(fpos, r_mp, r_marks)) begin
                    st = ST_MARKED; rep = 1'b1; rpos = fpos;
                end else if (r_mp >= MW'(MARK_DEPTH)) st = ST_MFULL;
                else begin
                    n_marks[r_mp[QW-1:0]] = fpos;
                    n_mp = r_mp + 1'b1;
                    rep = 1'b1; rpos = fpos;
                end
            end
            OP_PURGE: begin
                if (r_mp == '0) st = ST_BADPOS;
                else begin
                    if (CW'(m0) < r_used) begin
                        cmd.del = 1'b1; del_p = m0; n_used = r_used - 1'b1;
                        rpos = m0; okey_k = c_key[m0]; oval = c_val[m0];
                        for (int i = 1; i < MARK_DEPTH; i++)
                            if (MW'(i) < r_mp && r_marks[i] > m0)
                                n_marks[i] = r_marks[i] - 1'b1;
                    end else st = ST_BADPOS;
                    for (int i = 0; i + 1 < MARK_DEPTH; i++)
                        n_marks[i] = n_marks[i + 1];
                    n_mp = r_mp - 1'b1;
                end
            end
            OP_READ: begin
                if ({1'b0, r_rp} >= 9'(r_used) || 32'(r_rp) >= CAPACITY) st = ST_BADPOS;
                else begin rep = 1'b1; rpos = r_rp[PW-1:0]; end
            end
            default: st = ST_BADPOS;
        endcase
        if (rep) begin
            hit = 1'b1; okey_k = c_key[rpos]; oval = c_val[rpos];
            ism = marked(rpos, n_mp, n_marks);
        end
        if (!r_cmp) cmd = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            o_valid <= 1'b0;
            r_used  <= '0;
            r_mp    <= '0;
        end else begin
            if (acc) r_busy <= 1'b1;
            if (r_cmp) begin
                r_busy  <= 1'b0;
                o_valid <= 1'b1;
                r_used  <= n_used;
                r_mp    <= n_mp;
            end else if (o_valid && !i_stall) o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp) begin
            r_marks       <= n_marks;
            o_status      <= st;
            o_hit         <= hit;
            o_position    <= 8'(rpos);
            o_key_out     <= 64'(okey_k);
            o_value_out   <= oval;
            o_is_marked   <= ism;
            o_entry_count <= 9'(n_used);
            o_mark_count  <= 3'(n_mp);
        end
    end
endmodule

// File: design/sltt_checker.sv
// Port-level checks for the sorted leaf table unit, bound to the top level
`timescale 1ns / 1ps
module sltt_checker import sltt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic        o_hit,
    input logic [8:0]  o_entry_count,
    input logic [2:0]  o_mark_count
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)) else $error("result dropped");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("second transfer during work");
    a_fail_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL || o_status == ST_NOTFND || o_status == ST_MFULL)
        |-> !o_hit) else $error("hit on failure");
    a_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_mark_count <= 3'd4) else $error("mark count out of range");
    a_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= 9'd256) else $error("entry count out of range");
endmodule

bind sorted_leaf_table_with_tombstones_unit sltt_checker u_sltt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status), .o_hit(o_hit),
    .o_entry_count(o_entry_count), .o_mark_count(o_mark_count)
);

// File: tb/tb.sv
// Testbench for the sorted leaf table unit with pending-delete marks
`timescale 1ns / 1ps
module tb;
    import sltt_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic        hit;
        logic [7:0]  position;
        logic [63:0] key_out;
        logic [63:0] value_out;
        logic        is_marked;
        logic [8:0]  entry_count;
        logic [2:0]  mark_count;
    } leaf_res_t;

    localparam int TABLE_SLOTS = 256;
    localparam int MARK_SLOTS  = 4;
    localparam logic [1:0] ADDR_MAX_ENTRIES = 2'd0;
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_opcode = OP_LOOKUP;
    logic [63:0] i_search_key = '0;
    logic [63:0] i_entry_value = '0;
    logic [7:0]  i_read_position = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic        o_hit;
    logic [7:0]  o_position;
    logic [63:0] o_key_out;
    logic [63:0] o_value_out;
    logic        o_is_marked;
    logic [8:0]  o_entry_count;
    logic [2:0]  o_mark_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sorted_leaf_table_with_tombstones_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow table state
    logic [63:0] shadow_keys [TABLE_SLOTS];
    logic [63:0] shadow_vals [TABLE_SLOTS];
    int          shadow_used = 0;
    int          shadow_marks[$];
    int          entry_limit = 256;

    leaf_res_t   expected_results[$];
    logic [63:0] key_pool[32];
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          cycles = 0;
    bit          idling_on = 1'b1;
    int          hold_off_left = 0;
    int          stall_burst = 0;

    function automatic int find_key(logic [63:0] k);
        for (int i = 0; i < shadow_used; i++)
            if (shadow_keys[i] == k) return i;
        return -1;
    endfunction

    function automatic bit is_pos_marked(int p);
        foreach (shadow_marks[i])
            if (shadow_marks[i] == p) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void fill_entry(ref leaf_res_t r, input int p);
        r.hit = 1'b1;
        r.position = p[7:0];
        r.key_out = shadow_keys[p];
        r.value_out = shadow_vals[p];
        r.is_marked = is_pos_marked(p);
    endfunction

    function automatic leaf_res_t apply_leaf_op(logic [2:0] op, logic [63:0] k,
                                                logic [63:0] v, logic [7:0] rp);
        leaf_res_t r;
        int f;
        int p;
        r = '0;
        case (op)
            OP_LOOKUP: begin
                f = find_key(k);
                if (f < 0) r.status = ST_NOTFND;
                else fill_entry(r, f);
            end
            OP_INSERT: begin
                f = find_key(k);
                if (f >= 0) begin
                    r.status = ST_DUP;
                    fill_entry(r, f);
                end else if (shadow_used >= entry_limit) begin
                    r.status = ST_FULL;
                end else begin
                    p = 0;
                    while (p < shadow_used && shadow_keys[p] < k) p++;
                    for (int i = shadow_used; i > p; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_vals[i] = shadow_vals[i-1];
                    end
                    shadow_keys[p] = k;
                    shadow_vals[p] = v;
                    shadow_used++;
                    foreach (shadow_marks[i])
                        if (shadow_marks[i] >= p) shadow_marks[i]++;
                    r.position = p[7:0];
                    r.key_out = k;
                    r.value_out = v;
                end
            end
            OP_MARK: begin
                f = find_key(k);
                if (f < 0) begin
                    r.status = ST_NOTFND;
                end else if (is_pos_marked(f)) begin
                    r.status = ST_MARKED;
                    fill_entry(r, f);
                end else if (shadow_marks.size() >= MARK_SLOTS) begin
                    r.status = ST_MFULL;
                end else begin
                    shadow_marks = {shadow_marks, f};
                    fill_entry(r, f);
                end
            end
            OP_PURGE: begin
                if (shadow_marks.size() == 0) begin
                    r.status = ST_BADPOS;
                end else begin
                    p = shadow_marks.pop_front();
                    r.position = p[7:0];
                    r.key_out = shadow_keys[p];
                    r.value_out = shadow_vals[p];
                    for (int i = p; i + 1 < shadow_used; i++) begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_vals[i] = shadow_vals[i+1];
                    end
                    shadow_used--;
                    foreach (shadow_marks[i])
                        if (shadow_marks[i] > p) shadow_marks[i]--;
                end
            end
            OP_READ: begin
                if (rp >= shadow_used) r.status = ST_BADPOS;
                else fill_entry(r, rp);
            end
            default: r.status = ST_BADPOS;
        endcase
        r.entry_count = shadow_used[8:0];
        r.mark_count = 3'(shadow_marks.size());
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h, want %0h (result %0d)", what, got, want, results_seen);
        mismatches++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer", 64'(o_status), 64'd0);
            end else begin
                leaf_res_t e;
                e = expected_results.pop_front();
                if (o_status !== e.status)
                    report_mismatch("status", 64'(o_status), 64'(e.status));
                if (o_hit !== e.hit) report_mismatch("hit", 64'(o_hit), 64'(e.hit));
                if (o_position !== e.position)
                    report_mismatch("position", 64'(o_position), 64'(e.position));
                if (o_key_out !== e.key_out) report_mismatch("key_out", o_key_out, e.key_out);
                if (o_value_out !== e.value_out)
                    report_mismatch("value_out", o_value_out, e.value_out);
                if (o_is_marked !== e.is_marked)
                    report_mismatch("is_marked", 64'(o_is_marked), 64'(e.is_marked));
                if (o_entry_count !== e.entry_count)
                    report_mismatch("entry_count", 64'(o_entry_count), 64'(e.entry_count));
                if (o_mark_count !== e.mark_count)
                    report_mismatch("mark_count", 64'(o_mark_count), 64'(e.mark_count));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 400000) begin
            $display("timeout at cycle %0d", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stall: long hold-offs take priority over random bursts
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            i_stall = 1'b1;
            hold_off_left--;
        end else if (!idling_on) begin
            i_stall = 1'b0;
            stall_burst = 0;
        end else if (stall_burst > 0) begin
            i_stall = 1'b1;
            stall_burst--;
        end else if ($urandom_range(0, 7) == 0) begin
            i_stall = 1'b1;
            stall_burst = $urandom_range(0, 16);
        end else begin
            i_stall = 1'b0;
        end
    end

    task automatic send_item(logic [2:0] op, logic [63:0] k, logic [63:0] v, logic [7:0] rp);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_opcode = op;
        i_search_key = k;
        i_entry_value = v;
        i_read_position = rp;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        expected_results = {expected_results, apply_leaf_op(op, k, v, rp)};
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_entries(int val);
        drain_results();
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = ADDR_MAX_ENTRIES;
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        entry_limit = (val & 32'h1FF) > TABLE_SLOTS ? TABLE_SLOTS : (val & 32'h1FF);
    endtask

    function automatic logic [63:0] pick_key();
        if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 31)];
        return {$urandom, $urandom};
    endfunction

    task automatic random_item();
        int sel;
        logic [2:0] op;
        sel = $urandom_range(0, 99);
        if (sel < 30) op = OP_INSERT;
        else if (sel < 48) op = OP_LOOKUP;
        else if (sel < 68) op = OP_MARK;
        else if (sel < 84) op = OP_PURGE;
        else if (sel < 96) op = OP_READ;
        else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        send_item(op, pick_key(), {$urandom, $urandom},
                  $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 40)));
    endtask

    task automatic test_directed();
        logic [63:0] ones;
        ones = '1;
        send_item(OP_LOOKUP, 64'd5, '0, 8'd0);
        send_item(OP_READ, '0, '0, 8'd0);
        send_item(OP_PURGE, '0, '0, 8'd0);
        send_item(OP_MARK, 64'd5, '0, 8'd0);
        send_item(OP_INSERT, ones, ones, 8'd0);
        send_item(OP_INSERT, 64'd0, 64'd0, 8'd0);
        send_item(OP_INSERT, 64'd100, 64'h1234, 8'd0);
        send_item(OP_INSERT, 64'd200, 64'h5678, 8'd0);
        send_item(OP_INSERT, 64'd100, 64'h9999, 8'd0);
        send_item(OP_MARK, 64'd100, '0, 8'd0);
        send_item(OP_MARK, 64'd100, '0, 8'd0);
        send_item(OP_MARK, ones, '0, 8'd0);
        send_item(OP_MARK, 64'd0, '0, 8'd0);
        send_item(OP_MARK, 64'd200, '0, 8'd0);
        send_item(OP_INSERT, 64'd50, 64'hAAAA, 8'd0);
        send_item(OP_MARK, 64'd50, '0, 8'd0);
        send_item(OP_LOOKUP, 64'd200, '0, 8'd0);
        send_item(OP_READ, '0, '0, 8'd255);
        send_item(OP_READ, '0, '0, 8'd4);
        send_item(OP_UNUSED_LO, '0, '0, 8'd0);
        send_item(OP_UNUSED_HI, '0, '0, 8'd0);
        for (int i = 0; i < 4; i++) send_item(OP_PURGE, '0, '0, 8'd0);
    endtask

    task automatic test_entry_limit();
        int limits[4] = '{2, 1, 0, 511};
        foreach (limits[j]) begin
            write_max_entries(limits[j]);
            for (int i = 0; i < 12; i++) random_item();
        end
    endtask

    task automatic test_backpressure();
        drain_results();
        hold_off_left = 300;
        for (int i = 0; i < 20; i++) random_item();
        drain_results();
        for (int i = 0; i < 20; i++) random_item();
    endtask

    task automatic test_random();
        int limits[4] = '{300, 8, 256, 1};
        foreach (limits[j]) begin
            write_max_entries(limits[j]);
            for (int i = 0; i < 75; i++) random_item();
        end
        write_max_entries(256);
        idling_on = 1'b0;
        for (int i = 0; i < 40; i++) random_item();
    endtask

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 32; i++) key_pool[i] = {$urandom, $urandom};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_entry_limit();
        test_backpressure();
        test_random();
        drain_results();
        repeat (20) @(posedge i_clk);
        $display("Covered all opcodes, duplicate/full/mark-queue limits, entry limits 0..511,");
        $display("  %0d transfers in, %0d checked out, with stalls on both sides", items_sent,
                 results_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
